>>> hdl/fpba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and constants of the fit policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

    localparam int BLOCKS = 32;
    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

    localparam int KIND_W = 1;
    localparam int BINDEX_W = 5;
    localparam int SIZE_W = 16;
    localparam int MODE_W = 2;
    localparam int COUNT_W = 6;

    localparam int CMP_W = (IDX_W > BINDEX_W) ? IDX_W : BINDEX_W;
    localparam int LIM_W = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = COUNT_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_FIT_MODE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b1;

    localparam logic [MODE_W-1:0] FIT_MODE_RESET = MODE_FIRST;
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [SIZE_W-1:0]  size;
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] limit;
        logic               found;
        logic [IDX_W-1:0]   pick;
        logic [SIZE_W-1:0]  pick_val;
    } scan_pkt_t;

    typedef struct packed {
        logic              en;
        logic [CMP_W-1:0]  idx;
        logic [SIZE_W-1:0] data;
    } cell_cmd_t;

endpackage

>>> hdl/fpba_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_ifs
// Handshake channels of the allocator: requests, results and configuration.
// ----------------------------------------------------------------------------
interface fpba_req_if import fpba_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [BINDEX_W-1:0] block_index;
    logic [SIZE_W-1:0]   size_value;

    modport source (output valid, output kind, output block_index, output size_value,
                    input ready);
    modport sink (input valid, input kind, input block_index, input size_value,
                  output ready);
endinterface

interface fpba_rsp_if import fpba_pkg::*;;
    logic                valid;
    logic                ready;
    logic                granted;
    logic [BINDEX_W-1:0] chosen_block;
    logic [SIZE_W-1:0]   left_in_block;

    modport source (output valid, output granted, output chosen_block,
                    output left_in_block, input ready);
    modport sink (input valid, input granted, input chosen_block,
                  input left_in_block, output ready);
endinterface

interface fpba_cfg_if import fpba_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

>>> hdl/fpba_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_cell
// One table entry with its share of the scan: it updates the passing
// candidate and hands it to the next cell.
// ----------------------------------------------------------------------------
module fpba_cell import fpba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  cell_cmd_t        wr,
    input  cell_cmd_t        chg,
    input  scan_pkt_t        pkt_in,
    output scan_pkt_t        pkt_out
);

    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_next;
    scan_pkt_t         pkt_reg;
    scan_pkt_t         pkt_next;
    logic              in_range;
    logic              fits;
    logic              take;

    always_comb
    begin
        size_next = size_reg;
        priority if (wr.en && (wr.idx == CMP_W'(cell_idx)))
        begin
            size_next = wr.data;
        end
        else if (chg.en && (chg.idx == CMP_W'(cell_idx)))
        begin
            size_next = size_reg - chg.data;
        end
        else
        begin
            size_next = size_reg;
        end
    end

    always_comb
    begin
        in_range = LIM_W'(cell_idx) < LIM_W'(pkt_in.limit);
        fits = pkt_in.valid && in_range && (size_reg >= pkt_in.size);
        unique case (pkt_in.mode)
            MODE_BEST:  take = fits && (!pkt_in.found || (size_reg < pkt_in.pick_val));
            MODE_WORST: take = fits && (!pkt_in.found || (size_reg > pkt_in.pick_val));
            default:    take = fits && !pkt_in.found;
        endcase
        pkt_next = pkt_in;
        if (take)
        begin
            pkt_next.found = 1'b1;
            pkt_next.pick = cell_idx;
            pkt_next.pick_val = size_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
            pkt_reg <= '0;
        end
        else
        begin
            size_reg <= size_next;
            pkt_reg <= pkt_next;
        end
    end

    assign pkt_out = pkt_reg;

endmodule

>>> hdl/fit_policy_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Free size table held in a row of cells; each request walks the row once
// and charges the block chosen by first, best or worst fit.
//
// Channel  Direction  Carries
// req      in         kind, block_index, size_value
// rsp      out        granted, chosen_block, left_in_block
// cfg      in         addr (0 fit_mode, 1 block_count), data
//
// A load is written into its cell and leaves req ready. A request walks
// the cell row one cell per cycle; its result appears on rsp when req
// becomes ready again. Reset clears the table, sets first fit and 32 blocks.
// While a result waits on a stalled rsp, one more request may be accepted
// and scanned; req then stays low until the waiting result is taken.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator import fpba_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    fpba_req_if.sink    req,
    fpba_rsp_if.source  rsp,
    fpba_cfg_if.sink    cfg
);

    state_t              state_reg;
    state_t              state_next;
    logic [MODE_W-1:0]   fit_mode_reg;
    logic [COUNT_W-1:0]  block_count_reg;
    logic                res_granted_reg;
    logic [BINDEX_W-1:0] res_block_reg;
    logic [SIZE_W-1:0]   res_left_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_granted_reg;
    logic [BINDEX_W-1:0] out_block_reg;
    logic [SIZE_W-1:0]   out_left_reg;
    logic                req_fire;
    logic                out_load;
    logic                tail_done;
    cell_cmd_t           wr_cmd;
    cell_cmd_t           chg_cmd;
    scan_pkt_t           head_pkt;
    scan_pkt_t           chain [BLOCKS+1];

    assign req_fire = req.valid && req.ready;
    assign tail_done = (state_reg == ST_SCAN) && chain[BLOCKS].valid;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.kind == KIND_REQUEST))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chain[BLOCKS].valid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = (state_reg == ST_IDLE);
        out_load = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);
    end

    always_comb
    begin
        wr_cmd.en = req_fire && (req.kind == KIND_LOAD);
        wr_cmd.idx = CMP_W'(req.block_index);
        wr_cmd.data = req.size_value;

        chg_cmd.en = tail_done && chain[BLOCKS].found;
        chg_cmd.idx = CMP_W'(chain[BLOCKS].pick);
        chg_cmd.data = chain[BLOCKS].size;

        head_pkt.valid = req_fire && (req.kind == KIND_REQUEST);
        head_pkt.size = req.size_value;
        head_pkt.mode = fit_mode_reg;
        head_pkt.limit = block_count_reg;
        head_pkt.found = 1'b0;
        head_pkt.pick = '0;
        head_pkt.pick_val = '0;
    end

    assign chain[0] = head_pkt;

    for (genvar i = 0; i < BLOCKS; i++)
    begin : g_cell
        fpba_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(i)),
            .wr       (wr_cmd),
            .chg      (chg_cmd),
            .pkt_in   (chain[i]),
            .pkt_out  (chain[i+1])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fit_mode_reg <= FIT_MODE_RESET;
            block_count_reg <= BLOCK_COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.addr)
                    CFG_FIT_MODE:    fit_mode_reg <= cfg.data[MODE_W-1:0];
                    CFG_BLOCK_COUNT: block_count_reg <= cfg.data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_done)
        begin
            res_granted_reg <= chain[BLOCKS].found;
            if (chain[BLOCKS].found)
            begin
                res_block_reg <= BINDEX_W'(chain[BLOCKS].pick);
                res_left_reg <= chain[BLOCKS].pick_val - chain[BLOCKS].size;
            end
            else
            begin
                res_block_reg <= '0;
                res_left_reg <= '0;
            end
        end
        if (out_load)
        begin
            out_granted_reg <= res_granted_reg;
            out_block_reg <= res_block_reg;
            out_left_reg <= res_left_reg;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.granted = out_granted_reg;
    assign rsp.chosen_block = out_block_reg;
    assign rsp.left_in_block = out_left_reg;

endmodule
